// ===== src/triangle_index_generator_defines.svh =====
// Assertion macros for the triangle index generator top module.
// Depends on nothing; included by the top module, which checks its own logic.
`ifndef TRIANGLE_INDEX_GENERATOR_DEFINES_SVH
`define TRIANGLE_INDEX_GENERATOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TIG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tig check failed in the same cycle");

// Checks that the consequent holds in the cycle after the antecedent.
`define TIG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tig check failed one cycle later");

`endif

// ===== src/tig_pkg.sv =====
// Types and constants shared by the triangle index generator.
// Depends on nothing; used by the response interface and all modules.
package tig_pkg;

  localparam int CNT_W = 13;
  localparam int IDX_W = 25;
  localparam int CNT_MAX = (2 ** CNT_W) - 1;
  localparam int MAX_ORDER_DEFAULT = 4096;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PACKED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIAG = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             packed_mode;
    logic             upper_mode;
    logic             include_diag;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic             last;
  } pos_t;

  typedef struct packed {
    logic load_prod;
    logic load_out;
  } addr_ctl_t;

endpackage

// ===== src/tig_channels.sv =====
// Valid/ready channel interfaces for request and response items.
// Depends on tig_pkg for the payload widths.
interface tig_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface tig_rsp_if import tig_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic             last;

  modport source (output valid, output index, output last, input ready);
  modport sink (input valid, input index, input last, output ready);
endinterface

// ===== src/triangle_index_generator.sv =====
// Triangle index generator: every request item yields the next 1-based index of the
// chosen triangle of an order-n square array, column by column, in full column-major
// or packed triangular addressing; the final index is flagged and the sequence wraps.
// The row/column counter loop steps once per accepted item, so one item is accepted
// per cycle unless the output stalls. An accepted request is registered, then its
// index is formed over two registered stages (products, then the sum). Requests for
// an empty triangle are accepted and give no result. The block needs no warm-up after
// reset. Configuration must be written only while idle; this is not enforced.
`include "triangle_index_generator_defines.svh"

module triangle_index_generator import tig_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tig_req_if.sink               req,
  tig_rsp_if.source             rsp
);

  localparam logic [CNT_W-1:0] MAX_N =
    CNT_W'((MAX_ORDER > CNT_MAX) ? CNT_MAX : MAX_ORDER);

  logic [CNT_W-1:0] order;
  logic             packed_mode;
  logic             upper_mode;
  logic             include_diag;
  cfg_t             cfg;

  pos_t      cur;
  pos_t      s1;
  logic      empty;
  logic      accept;
  logic      v1, v2, ov;
  logic      rdy2, rdy3;
  addr_ctl_t ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= '0;
      packed_mode <= 1'b0;
      upper_mode <= 1'b1;
      include_diag <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORDER:  order <= cfg_data;
        REG_PACKED: packed_mode <= cfg_data[0];
        REG_UPPER:  upper_mode <= cfg_data[0];
        REG_DIAG:   include_diag <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    cfg.n = (order > MAX_N) ? MAX_N : order;
    cfg.packed_mode = packed_mode;
    cfg.upper_mode = upper_mode;
    cfg.include_diag = include_diag;
  end

  // Each stage takes a new item when it is empty or its item moves on.
  assign rdy3 = !ov || rsp.ready;
  assign rdy2 = !v2 || rdy3;
  assign req.ready = !v1 || rdy2;
  assign accept = req.valid && req.ready;
  assign ctl.load_prod = v1 && rdy2;
  assign ctl.load_out = v2 && rdy3;

  tig_pos u_pos (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (accept),
    .restart (req.restart),
    .cur     (cur),
    .empty   (empty)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (req.ready) begin
        v1 <= accept && !empty;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        ov <= v2;
      end
    end
  end

  tig_addr u_addr (
    .clk   (clk),
    .cfg   (cfg),
    .ctl   (ctl),
    .pos   (s1),
    .index (rsp.index),
    .last  (rsp.last)
  );

  assign rsp.valid = ov;

  `TIG_ASSERT_NEXT(a_req_enters, clk, rst, accept && !empty, v1)
  `TIG_ASSERT_NEXT(a_stage_moves, clk, rst, v1 && rdy2, v2)
  `TIG_ASSERT_NOW(a_index_nonzero, clk, rst, rsp.valid, rsp.index != '0)

endmodule

// ===== src/tig_pos.sv =====
// Column and row counters that walk the chosen triangle, one element per item.
// Depends on tig_pkg.
module tig_pos import tig_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic advance,
  input  logic restart,
  output pos_t cur,
  output logic empty
);

  logic [CNT_W-1:0] col;
  logic [CNT_W-1:0] row;
  logic [CNT_W:0]   n14, c14, r14;
  logic [CNT_W:0]   lo_c, end_c, first_c, first_r;
  logic [CNT_W:0]   pc, pr, pend, lc, lr;
  logic [CNT_W:0]   col_next, row_next;
  logic             stale, is_last;

  always_comb begin
    n14 = {1'b0, cfg.n};
    c14 = {1'b0, col};
    r14 = {1'b0, row};
    empty = (cfg.n == '0) || (!cfg.include_diag && n14 < (CNT_W+1)'(2));

    lo_c = cfg.upper_mode ? '0 : (cfg.include_diag ? c14 : c14 + 1'b1);
    end_c = cfg.upper_mode ? (cfg.include_diag ? c14 + 1'b1 : c14) : n14;
    // A stored position outside the current triangle starts over.
    stale = (c14 >= n14) || (r14 < lo_c) || (r14 >= end_c);

    first_c = (cfg.upper_mode && !cfg.include_diag) ? (CNT_W+1)'(1) : '0;
    first_r = (!cfg.upper_mode && !cfg.include_diag) ? (CNT_W+1)'(1) : '0;

    if (restart || stale) begin
      pc = first_c;
      pr = first_r;
    end else begin
      pc = c14;
      pr = r14;
    end

    if (cfg.upper_mode) begin
      lc = n14 - 1'b1;
      lr = cfg.include_diag ? n14 - 1'b1 : n14 - (CNT_W+1)'(2);
    end else begin
      lc = cfg.include_diag ? n14 - 1'b1 : n14 - (CNT_W+1)'(2);
      lr = n14 - 1'b1;
    end
    is_last = (pc == lc) && (pr == lr);

    pend = cfg.upper_mode ? (cfg.include_diag ? pc + 1'b1 : pc) : n14;

    if (is_last) begin
      col_next = first_c;
      row_next = first_r;
    end else if (pr + 1'b1 < pend) begin
      col_next = pc;
      row_next = pr + 1'b1;
    end else begin
      col_next = pc + 1'b1;
      row_next = cfg.upper_mode ? '0 :
                 (cfg.include_diag ? pc + 1'b1 : pc + (CNT_W+1)'(2));
    end

    cur.col = pc[CNT_W-1:0];
    cur.row = pr[CNT_W-1:0];
    cur.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance && !empty) begin
      col <= col_next[CNT_W-1:0];
      row <= row_next[CNT_W-1:0];
    end
  end

endmodule

// ===== src/tig_addr.sv =====
// Two-stage index computation: products of the column, then the final sum.
// Depends on tig_pkg.
module tig_addr import tig_pkg::*; (
  input  logic             clk,
  input  cfg_t             cfg,
  input  addr_ctl_t        ctl,
  input  pos_t             pos,
  output logic [IDX_W-1:0] index,
  output logic             last
);

  localparam int PA_W = 2 * CNT_W;
  localparam int PB_W = 2 * CNT_W + 1;

  logic [CNT_W:0]     col_adj;
  logic [PA_W-1:0]    prod_a;
  logic [PB_W-1:0]    prod_b;
  pos_t               pos_q;
  logic [IDX_W-1:0]   a25, h25, r25, c25, index_next;
  logic [PB_W-2:0]    half;

  // Packed upper uses c*(c+1), packed lower uses c*(c-1), zero for column 0.
  assign col_adj = cfg.upper_mode ? {1'b0, pos.col} + 1'b1 :
                   (pos.col != '0 ? {1'b0, pos.col} - 1'b1 : '0);

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_a <= pos.col * cfg.n;
      prod_b <= {1'b0, pos.col} * col_adj;
      pos_q <= pos;
    end
  end

  always_comb begin
    half = prod_b[PB_W-1:1];
    a25 = prod_a[IDX_W-1:0];
    h25 = half[IDX_W-1:0];
    r25 = IDX_W'(pos_q.row);
    c25 = IDX_W'(pos_q.col);
    if (!cfg.packed_mode) begin
      index_next = a25 + r25 + 1'b1;
    end else if (cfg.upper_mode) begin
      index_next = h25 + r25 + 1'b1;
    end else begin
      index_next = a25 - h25 + r25 - c25 + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      index <= index_next;
      last <= pos_q.last;
    end
  end

endmodule
